[rtl/fcb_pkg.sv]
// Package for the flow counter with blocklist: item types, verdict codes,
// sequencer states, table response and write request structs and protocol constants. No dependencies.
`default_nettype none
package fcb_pkg;

  localparam int KEY_W  = 104;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [31:0] BLOCK_MARK     = 32'd1;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_DROP  = 2'd1,
    VERDICT_ABORT = 2'd2
  } verdict_t;

  typedef enum logic [0:0] {
    KIND_PACKET = 1'b0,
    KIND_BLOCK  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BWAIT,
    ST_PWAIT,
    ST_FWAIT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic        kind;
    logic        eth_ok;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic        l4_ok;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] block_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        counted;
    logic [31:0] flow_packets;
    logic        table_full;
  } out_item_t;

  // Status a table returns at the end of a scan.
  typedef struct packed {
    logic              done;
    logic              hit;
    logic              full;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } tbl_rsp_t;

  // Write request into a table.
  typedef struct packed {
    logic              en;
    logic              is_new;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } tbl_wr_t;

endpackage
`default_nettype wire

[rtl/fcb_table.sv]
// Exact-match key table: one synchronous memory, fill count, linear scanner.
// Depends on fcb_pkg.
`default_nettype none
module fcb_table #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [fcb_pkg::KEY_W-1:0]  key,
  input  wire fcb_pkg::tbl_wr_t           wr,
  output fcb_pkg::tbl_rsp_t               rsp
);
  import fcb_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = KEY_W + DATA_W;
  localparam logic [CW-1:0] DEPTH = CW'(ENTRIES);

  logic [EW-1:0] mem [ENTRIES];
  logic [EW-1:0] rd_q;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic          busy_r, busy_nxt;
  logic          more, hit_now, issue, done;

  // scan: entries below the fill count are valid, checked one a cycle
  assign more    = idx_r < fill_r;
  assign hit_now = chk_vld_r && (rd_q[EW-1:DATA_W] == key);
  assign done    = busy_r && (hit_now || (!chk_vld_r && !more));
  assign issue   = busy_r && more && !hit_now;

  always_comb begin
    busy_nxt    = busy_r;
    idx_nxt     = idx_r;
    chk_vld_nxt = issue;
    chk_idx_nxt = idx_r[IW-1:0];
    fill_nxt    = fill_r;
    if (start) begin
      busy_nxt    = 1'b1;
      idx_nxt     = '0;
      chk_vld_nxt = 1'b0;
    end else if (done) begin
      busy_nxt    = 1'b0;
      chk_vld_nxt = 1'b0;
    end else if (issue) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (wr.en && wr.is_new) fill_nxt = fill_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      chk_vld_r <= 1'b0;
      fill_r    <= '0;
      idx_r     <= '0;
    end else begin
      busy_r    <= busy_nxt;
      chk_vld_r <= chk_vld_nxt;
      fill_r    <= fill_nxt;
      idx_r     <= idx_nxt;
    end
    chk_idx_r <= chk_idx_nxt;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (issue) rd_q <= mem[idx_r[IW-1:0]];
    if (wr.en) mem[wr.idx[IW-1:0]] <= {wr.key, wr.data};
  end

  always_comb begin
    rsp.done = done;
    rsp.hit  = hit_now;
    rsp.full = (fill_r == DEPTH);
    rsp.idx  = hit_now ? IDX_W'(chk_idx_r) : IDX_W'(fill_r);
    rsp.data = rd_q[DATA_W-1:0];
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH) else $error("fill count beyond depth");
  a_hit_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    hit_now |-> (CW'(chk_idx_r) < fill_r)) else $error("hit on unfilled entry");
  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !done) |-> !wr.en) else $error("table written during scan");
`endif

endmodule
`default_nettype wire

[rtl/flow_counter_with_blocklist.sv]
// Flow counter with blocklist. One item at a time; an item settled by header
// flags goes straight to the result state and then to the output register.
// Each table scan reads one memory entry per cycle: the block table for every
// lookup, then the flow table for packets that are not dropped.
// Synchronous active-low reset empties both tables at once via fill counts.
`default_nettype none
module flow_counter_with_blocklist #(
  parameter int FLOW_ENTRIES = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fcb_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fcb_pkg::out_item_t      out_item
);
  import fcb_pkg::*;

  state_t    state_r, state_nxt;
  in_item_t  item_r;
  out_item_t res_r, res_nxt;
  out_item_t out_r;
  logic      out_valid_r, out_valid_nxt;
  logic      blk_start, flw_start;
  tbl_wr_t   blk_wr, flw_wr;
  tbl_rsp_t  blk_rsp, flw_rsp;
  logic [KEY_W-1:0] key;
  logic      accept, l4_proto, out_free;

  assign key = {item_r.src_addr, item_r.dst_addr, item_r.src_port,
                item_r.dst_port, item_r.ip_protocol};
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign l4_proto = (in_item.ip_protocol == PROTO_TCP) ||
                    (in_item.ip_protocol == PROTO_UDP);

  fcb_table #(.ENTRIES(FLOW_ENTRIES)) u_blk (
    .clk(clk), .rst_n(rst_n), .start(blk_start), .key(key), .wr(blk_wr), .rsp(blk_rsp));
  fcb_table #(.ENTRIES(FLOW_ENTRIES)) u_flw (
    .clk(clk), .rst_n(rst_n), .start(flw_start), .key(key), .wr(flw_wr), .rsp(flw_rsp));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    blk_start = 1'b0;
    flw_start = 1'b0;
    blk_wr    = '{en: 1'b0, is_new: ~blk_rsp.hit, idx: blk_rsp.idx, key: key,
                  data: item_r.block_value};
    flw_wr    = '{en: 1'b0, is_new: ~flw_rsp.hit, idx: flw_rsp.idx, key: key,
                  data: flw_rsp.hit ? flw_rsp.data + 32'd1 : 32'd1};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '{verdict: VERDICT_PASS, counted: 1'b0, flow_packets: '0,
                      table_full: 1'b0};
          priority if (in_item.kind == KIND_BLOCK) begin
            state_nxt = ST_BWAIT;
          end else if (!in_item.eth_ok) begin
            res_nxt.verdict = VERDICT_ABORT;
            state_nxt = ST_RESULT;
          end else if (in_item.ether_type != ETHERTYPE_IPV4 || !l4_proto) begin
            state_nxt = ST_RESULT;
          end else if (!in_item.l4_ok) begin
            res_nxt.verdict = VERDICT_ABORT;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_PWAIT;
          end
        end
      end
      ST_BWAIT: begin
        if (blk_rsp.done) begin
          if (blk_rsp.hit || !blk_rsp.full) blk_wr.en = 1'b1;
          else res_nxt.table_full = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_PWAIT: begin
        if (blk_rsp.done) begin
          if (blk_rsp.hit && blk_rsp.data == BLOCK_MARK) begin
            res_nxt.verdict = VERDICT_DROP;
            state_nxt = ST_RESULT;
          end else begin
            flw_start = 1'b1;
            state_nxt = ST_FWAIT;
          end
        end
      end
      ST_FWAIT: begin
        if (flw_rsp.done) begin
          if (flw_rsp.hit || !flw_rsp.full) begin
            flw_wr.en = 1'b1;
            res_nxt.counted = 1'b1;
            res_nxt.flow_packets = flw_wr.data;
          end else begin
            res_nxt.table_full = 1'b1;
          end
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // block scan starts as the item is latched
    if (state_r == ST_IDLE && (state_nxt == ST_BWAIT || state_nxt == ST_PWAIT))
      blk_start = 1'b1;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == ST_RESULT && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) item_r <= in_item;
    res_r <= res_nxt;
    if (state_r == ST_RESULT && out_free) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall) else $error("second item taken while one is in flight");
  a_verdict_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.verdict == VERDICT_PASS || out_r.verdict == VERDICT_DROP ||
                     out_r.verdict == VERDICT_ABORT)) else $error("illegal verdict code");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for flow_counter_with_blocklist: directed and random packet and
// blocklist items checked against an in-bench flow and blocklist table model.
// Depends on fcb_pkg and the flow_counter_with_blocklist RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fcb_pkg::*;

  localparam int ENTRIES   = 1024;
  localparam int IDLE_MAX  = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  flow_counter_with_blocklist #(.FLOW_ENTRIES(ENTRIES)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Table model: entries are appended in slot order since nothing is removed.
  logic [103:0] flow_key_tbl[$];
  logic [31:0]  flow_cnt_tbl[$];
  logic [103:0] blk_key_tbl[$];
  logic [31:0]  blk_val_tbl[$];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t r;
    logic [103:0] key;
    int idx;
    r = '0;
    key = {it.src_addr, it.dst_addr, it.src_port, it.dst_port, it.ip_protocol};
    if (it.kind == KIND_BLOCK) begin
      idx = -1;
      foreach (blk_key_tbl[i]) if (idx < 0 && blk_key_tbl[i] == key) idx = i;
      if (idx >= 0) blk_val_tbl[idx] = it.block_value;
      else if (blk_key_tbl.size() < ENTRIES) begin
        blk_key_tbl.push_back(key);
        blk_val_tbl.push_back(it.block_value);
      end else r.table_full = 1'b1;
    end else if (!it.eth_ok) begin
      r.verdict = VERDICT_ABORT;
    end else if (it.ether_type != ETHERTYPE_IPV4) begin
      r.verdict = VERDICT_PASS;
    end else if (it.ip_protocol != PROTO_TCP && it.ip_protocol != PROTO_UDP) begin
      r.verdict = VERDICT_PASS;
    end else if (!it.l4_ok) begin
      r.verdict = VERDICT_ABORT;
    end else begin
      idx = -1;
      foreach (blk_key_tbl[i]) if (idx < 0 && blk_key_tbl[i] == key) idx = i;
      if (idx >= 0 && blk_val_tbl[idx] == BLOCK_MARK) begin
        r.verdict = VERDICT_DROP;
      end else begin
        idx = -1;
        foreach (flow_key_tbl[i]) if (idx < 0 && flow_key_tbl[i] == key) idx = i;
        if (idx >= 0) begin
          flow_cnt_tbl[idx] = flow_cnt_tbl[idx] + 32'd1;
          r.counted = 1'b1;
          r.flow_packets = flow_cnt_tbl[idx];
        end else if (flow_key_tbl.size() < ENTRIES) begin
          flow_key_tbl.push_back(key);
          flow_cnt_tbl.push_back(32'd1);
          r.counted = 1'b1;
          r.flow_packets = 32'd1;
        end else r.table_full = 1'b1;
      end
    end
    return r;
  endfunction

  // Driver: offers items from the pending queue with random gaps.
  int gap = 0;
  logic in_acc_q = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc_q) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item <= pending_items.pop_front();
          in_valid <= 1'b1;
          gap <= ($urandom_range(0, 9) < 6) ? 0 :
                 ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        end else in_valid <= 1'b0;
      end
    end
  end

  // Input acceptance, sampled at the rising edge; prediction happens here.
  always @(posedge clk) begin
    in_acc_q <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_results.push_back(predict_verdict(in_item));
  end

  // Receiver stall: random gaps, and a long hold-off when asked.
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left <= 300;
      hold_request <= 1'b0;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 99) < 3) begin
        hold_left <= $urandom_range(10, 40);
        out_stall <= 1'b1;
      end else begin
        hold_left <= 0;
        out_stall <= ($urandom_range(0, 9) < 3);
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation: %p", out_item);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.verdict !== e.verdict) begin
          $error("verdict exp %0d got %0d", e.verdict, out_item.verdict); errors++;
        end
        if (out_item.counted !== e.counted) begin
          $error("counted exp %0d got %0d", e.counted, out_item.counted); errors++;
        end
        if (out_item.flow_packets !== e.flow_packets) begin
          $error("flow_packets exp %0d got %0d", e.flow_packets, out_item.flow_packets);
          errors++;
        end
        if (out_item.table_full !== e.table_full) begin
          $error("table_full exp %0d got %0d", e.table_full, out_item.table_full); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else if (!stim_done || expected_results.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic in_item_t make_packet(logic [31:0] sa, logic [31:0] da,
                                           logic [15:0] sp, logic [15:0] dp,
                                           logic [7:0] pr);
    in_item_t it;
    it = '0;
    it.kind = KIND_PACKET;
    it.eth_ok = 1'b1;
    it.ether_type = ETHERTYPE_IPV4;
    it.l4_ok = 1'b1;
    it.ip_protocol = pr;
    it.src_addr = sa; it.dst_addr = da; it.src_port = sp; it.dst_port = dp;
    it.block_value = $urandom;
    return it;
  endfunction

  in_item_t flows[16];

  initial begin
    in_item_t it;
    int r;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: extremes, every verdict path, blocklist overwrite and value 0.
    it = make_packet('1, '1, '1, '1, PROTO_TCP);
    pending_items.push_back(it);
    pending_items.push_back(it);
    it = make_packet('0, '0, '0, '0, PROTO_UDP);
    pending_items.push_back(it);
    it.eth_ok = 1'b0; pending_items.push_back(it);
    it.eth_ok = 1'b1; it.l4_ok = 1'b0; pending_items.push_back(it);
    it.l4_ok = 1'b1; it.ether_type = 16'h86DD; pending_items.push_back(it);
    it.ether_type = ETHERTYPE_IPV4; it.ip_protocol = 8'hFF; pending_items.push_back(it);
    it.ip_protocol = 8'd1; it.l4_ok = 1'b0; pending_items.push_back(it);
    it = make_packet(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, PROTO_TCP);
    pending_items.push_back(it);
    it.kind = KIND_BLOCK; it.block_value = BLOCK_MARK; it.eth_ok = 1'b0; it.l4_ok = 1'b0;
    pending_items.push_back(it);
    it.kind = KIND_PACKET; it.eth_ok = 1'b1; it.l4_ok = 1'b1; pending_items.push_back(it);
    it.kind = KIND_BLOCK; it.block_value = 32'd0; pending_items.push_back(it);
    it.kind = KIND_PACKET; pending_items.push_back(it);
    it.kind = KIND_BLOCK; it.block_value = '1; pending_items.push_back(it);
    it.kind = KIND_PACKET; pending_items.push_back(it);
    it.ip_protocol = PROTO_UDP; pending_items.push_back(it);

    // Flow pool for random traffic that revisits a handful of keys.
    foreach (flows[i]) flows[i] = make_packet($urandom, $urandom,
                                              16'($urandom), 16'($urandom),
                                              $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);

    for (int n = 0; n < 850; n++) begin
      r = $urandom_range(0, 99);
      if (n == 300) begin
        // long receiver hold-off while the sender keeps offering
        wait (pending_items.size() == 0);
        hold_request = 1'b1;
      end
      if (r < 55) begin
        it = flows[$urandom_range(0, 15)];
        it.block_value = $urandom;
      end else if (r < 70) begin
        it = make_packet($urandom, $urandom, 16'($urandom), 16'($urandom),
                         $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP);
      end else if (r < 82) begin
        it = flows[$urandom_range(0, 15)];
        it.kind = KIND_BLOCK;
        it.eth_ok = 1'($urandom); it.l4_ok = 1'($urandom); it.ether_type = 16'($urandom);
        it.block_value = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 2);
      end else begin
        // noise: random header flags and types
        it = $urandom_range(0, 1) ? flows[$urandom_range(0, 15)] :
             make_packet($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
        it.eth_ok = $urandom_range(0, 3) != 0;
        it.l4_ok = $urandom_range(0, 2) != 0;
        if ($urandom_range(0, 1)) it.ether_type = 16'($urandom);
        if ($urandom_range(0, 1)) it.ip_protocol = 8'($urandom);
        it.block_value = $urandom;
      end
      pending_items.push_back(it);
    end

    wait (pending_items.size() == 0 && !in_valid);
    stim_done = 1'b1;
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

[flow_counter_with_blocklist.f]
rtl/fcb_pkg.sv
rtl/fcb_table.sv
rtl/flow_counter_with_blocklist.sv
bench/tb_top.sv
